### sv/heq_pkg.sv
package heq_pkg;

  localparam int unsigned NumLevels = 256;
  localparam int unsigned LevelW = 8;
  localparam int unsigned DefMaxPixels = 1048576;
  localparam logic [7:0] TopLevel = 8'd255;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
    logic       last_pixel;
  } heq_in_t;

  typedef struct packed {
    logic [7:0] equalized_pixel;
    logic       end_of_image;
  } heq_out_t;

endpackage

### sv/histogram_equalizer.sv
// Histogram equalizer for 8-bit gray images, two passes over each image.
// Each pixel passes S_IDLE then S_CNT or S_MAP; a map-pass result is on the ports
// in the cycle after the request is accepted. out_valid is never stalled.
// The last count-pass pixel starts a table build, one level at a time through S_BRD,
// S_BDIV (bit-serial divider) and S_BWR; the last map-pass pixel starts a histogram clear.
// Reset (synchronous, rst_n low) sweeps both memories to zero; busy stays high.
module histogram_equalizer #(
  parameter int unsigned MAX_PIXELS = heq_pkg::DefMaxPixels
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  heq_pkg::heq_in_t  in_data,
  output logic              out_valid,
  output heq_pkg::heq_out_t out_data
);
  import heq_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned ProdW = CntW + 10;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PIXELS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CNT  = 3'd2;
  localparam logic [2:0] S_MAP  = 3'd3;
  localparam logic [2:0] S_BRD  = 3'd4;
  localparam logic [2:0] S_BDIV = 3'd5;
  localparam logic [2:0] S_BWR  = 3'd6;

  logic [CntW-1:0] bin_mem [NumLevels];
  logic [LevelW-1:0] lut_mem [NumLevels];

  logic [2:0] state_r, state_nxt;
  logic [8:0] idx_r, idx_nxt;
  logic last_r, last_nxt, clr_lut_r, clr_lut_nxt;
  logic [CntW-1:0] total_r, total_nxt, cdf_r, cdf_nxt;
  logic [ProdW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [ProdW-1:0] num_r, num_nxt;
  logic [8:0] quo_r, quo_nxt;
  logic [$clog2(ProdW+1)-1:0] bit_r, bit_nxt;
  logic [LevelW-1:0] rd_addr;
  logic [CntW-1:0] bin_q;
  logic [LevelW-1:0] lut_q;
  logic bin_we, lut_we;
  logic [LevelW-1:0] bin_wa, lut_wa;
  logic [CntW-1:0] bin_wd;
  logic [LevelW-1:0] lut_wd;
  logic [CntW-1:0] cdf_sum;
  logic [ProdW-1:0] trial;

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_wa] <= bin_wd;
    end
    if (lut_we) begin
      lut_mem[lut_wa] <= lut_wd;
    end
    bin_q <= bin_mem[rd_addr];
    lut_q <= lut_mem[rd_addr];
  end

  assign cdf_sum = cdf_r + bin_q;
  assign trial = {rem_r[ProdW-2:0], num_r[ProdW-1]};

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    last_nxt = last_r;
    clr_lut_nxt = clr_lut_r;
    total_nxt = total_r;
    cdf_nxt = cdf_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    bit_nxt = bit_r;
    rd_addr = idx_r[LevelW-1:0];
    bin_we = 1'b0;
    lut_we = 1'b0;
    bin_wa = idx_r[LevelW-1:0];
    lut_wa = idx_r[LevelW-1:0];
    bin_wd = '0;
    lut_wd = '0;
    out_valid = 1'b0;
    out_data = '0;
    unique case (state_r)
      S_CLR: begin
        bin_we = 1'b1;
        lut_we = clr_lut_r;
        if (idx_r[LevelW-1:0] == TopLevel) begin
          state_nxt = S_IDLE;
          clr_lut_nxt = 1'b0;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 9'd1;
        end
      end
      S_IDLE: begin
        if (start) begin
          rd_addr = in_data.pixel;
          idx_nxt = {1'b0, in_data.pixel};
          last_nxt = in_data.last_pixel;
          state_nxt = in_data.mode ? S_MAP : S_CNT;
        end
      end
      S_CNT: begin
        if (total_r < MaxCnt) begin
          bin_we = 1'b1;
          bin_wd = bin_q + CntW'(1);
          total_nxt = total_r + CntW'(1);
        end
        if (last_r) begin
          state_nxt = S_BRD;
          idx_nxt = '0;
          cdf_nxt = '0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MAP: begin
        out_valid = 1'b1;
        out_data.equalized_pixel = lut_q;
        out_data.end_of_image = last_r;
        if (last_r) begin
          state_nxt = S_CLR;
          idx_nxt = '0;
          total_nxt = '0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BRD: begin
        // Read issued here for idx_r; data lands in S_BDIV.
        rd_addr = idx_r[LevelW-1:0];
        state_nxt = S_BDIV;
      end
      S_BDIV: begin
        if (bit_r == '0) begin
          cdf_nxt = cdf_sum;
          // numerator = 510*cdf + total, denominator = 2*total
          num_nxt = (ProdW'(cdf_sum) << 9) - (ProdW'(cdf_sum) << 1) + ProdW'(total_r);
          den_nxt = ProdW'(total_r) << 1;
          rem_nxt = '0;
          quo_nxt = '0;
          bit_nxt = ($clog2(ProdW+1))'(ProdW);
        end else begin
          if (trial >= den_r) begin
            rem_nxt = trial - den_r;
            quo_nxt = {quo_r[7:0], 1'b1};
          end else begin
            rem_nxt = trial;
            quo_nxt = {quo_r[7:0], 1'b0};
          end
          num_nxt = num_r << 1;
          bit_nxt = bit_r - 1'b1;
          if (bit_r == 1) begin
            state_nxt = S_BWR;
          end
        end
      end
      S_BWR: begin
        lut_we = 1'b1;
        if (total_r == '0) begin
          lut_wd = '0;
        end else if (quo_r[8]) begin
          lut_wd = TopLevel;
        end else begin
          lut_wd = quo_r[7:0];
        end
        if (idx_r[LevelW-1:0] == TopLevel) begin
          state_nxt = S_IDLE;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 9'd1;
          rd_addr = idx_nxt[LevelW-1:0];
          state_nxt = S_BRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Quotient bits beyond 9 cannot be set: 510*cdf + total < 512 * 2*total.

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r <= '0;
      last_r <= 1'b0;
      clr_lut_r <= 1'b1;
      total_r <= '0;
      cdf_r <= '0;
      bit_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      last_r <= last_nxt;
      clr_lut_r <= clr_lut_nxt;
      total_r <= total_nxt;
      cdf_r <= cdf_nxt;
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

endmodule

### bench/tb_top.sv
module tb_top;
  import heq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PixelCap = 1048576;
  localparam int unsigned StallLimit = 40000;
  localparam int unsigned SettleCycles = 64;

  typedef enum logic {
    ModeCount = 1'b0,
    ModeMap = 1'b1
  } pass_mode_e;

  typedef struct {
    pass_mode_e mode;
    logic [7:0] pixel;
    logic last;
    logic known;
    logic [7:0] want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  heq_in_t in_data = '0;
  logic out_valid;
  heq_out_t out_data;

  histogram_equalizer u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Model copy of the block state.
  int unsigned bins_m [NumLevels];
  logic [7:0] lut_m [NumLevels];
  int unsigned total_m;

  heq_out_t pending_pixels [$];
  logic pending_known [$];
  logic [7:0] pending_typed [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_gap_pct = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void rebuild_lut();
    longint unsigned cdf;
    longint unsigned q;
    cdf = 0;
    for (int v = 0; v < NumLevels; v++) begin
      cdf += bins_m[v];
      if (total_m == 0) begin
        lut_m[v] = '0;
      end else begin
        q = (2 * cdf * 255 + total_m) / (2 * longint'(total_m));
        lut_m[v] = (q > 255) ? 8'd255 : q[7:0];
      end
    end
  endfunction

  // Update the model for one accepted request and queue its result if any.
  task automatic predict_equalized(input heq_in_t req, input logic known,
                                   input logic [7:0] want);
    heq_out_t res;
    if (req.mode == ModeCount) begin
      if (total_m < PixelCap) begin
        bins_m[req.pixel]++;
        total_m++;
      end
      if (req.last_pixel) rebuild_lut();
    end else begin
      res.equalized_pixel = lut_m[req.pixel];
      res.end_of_image = req.last_pixel;
      pending_pixels.push_back(res);
      pending_known.push_back(known);
      pending_typed.push_back(want);
      if (req.last_pixel) begin
        foreach (bins_m[i]) bins_m[i] = 0;
        total_m = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result", out_data.equalized_pixel, 0);
      end else begin
        if (pending_known[0] && out_data.equalized_pixel !== pending_typed[0])
          report_mismatch("typed value", out_data.equalized_pixel, pending_typed[0]);
        if (out_data.equalized_pixel !== pending_pixels[0].equalized_pixel)
          report_mismatch("equalized_pixel", out_data.equalized_pixel,
                          pending_pixels[0].equalized_pixel);
        if (out_data.end_of_image !== pending_pixels[0].end_of_image)
          report_mismatch("end_of_image", out_data.end_of_image,
                          pending_pixels[0].end_of_image);
        void'(pending_pixels.pop_front());
        void'(pending_known.pop_front());
        void'(pending_typed.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Present one request, wait until busy is low, then predict.
  // start stays high afterwards; the next call or the caller drives it again
  // in the same time step, once busy is low.
  task automatic send_request(input pass_mode_e mode, input logic [7:0] pixel,
                              input logic last, input logic known,
                              input logic [7:0] want);
    heq_in_t req;
    req.mode = mode;
    req.pixel = pixel;
    req.last_pixel = last;
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      in_data <= heq_in_t'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_equalized(req, known, want);
  endtask

  task automatic send_image(input int unsigned npix, input int unsigned spread);
    logic [7:0] img [$];
    logic [7:0] base;
    base = 8'($urandom);
    for (int i = 0; i < npix; i++) img.push_back(8'(base + $urandom_range(spread)));
    foreach (img[i]) send_request(ModeCount, img[i], i == npix - 1, 1'b0, '0);
    foreach (img[i]) begin
      send_request(ModeMap, ($urandom_range(9) == 0) ? 8'($urandom) : img[i],
                   i == npix - 1, 1'b0, '0);
    end
  endtask

  plan_row_t plan [] = '{
    // Map pass straight after reset reads an all-zero table.
    '{ModeMap, 8'd0, 1'b0, 1'b1, 8'd0},
    '{ModeMap, 8'd255, 1'b1, 1'b1, 8'd0},
    // Single-pixel image: everything at or above it maps to full scale.
    '{ModeCount, 8'd0, 1'b1, 1'b0, 8'd0},
    '{ModeMap, 8'd0, 1'b0, 1'b1, 8'd255},
    '{ModeMap, 8'd255, 1'b1, 1'b1, 8'd255},
    '{ModeCount, 8'd255, 1'b1, 1'b0, 8'd0},
    '{ModeMap, 8'd0, 1'b0, 1'b1, 8'd0},
    '{ModeMap, 8'd254, 1'b0, 1'b1, 8'd0},
    '{ModeMap, 8'd255, 1'b1, 1'b1, 8'd255},
    // Two pixels at the extremes give half scale, rounded up.
    '{ModeCount, 8'd0, 1'b0, 1'b0, 8'd0},
    '{ModeCount, 8'd255, 1'b1, 1'b0, 8'd0},
    '{ModeMap, 8'd0, 1'b0, 1'b1, 8'd128},
    '{ModeMap, 8'd128, 1'b0, 1'b1, 8'd128},
    '{ModeMap, 8'd255, 1'b1, 1'b1, 8'd255},
    // A repeated count pass keeps adding to the same histogram.
    '{ModeCount, 8'h55, 1'b1, 1'b0, 8'd0},
    '{ModeCount, 8'hAA, 1'b1, 1'b0, 8'd0},
    '{ModeCount, 8'h0F, 1'b0, 1'b0, 8'd0},
    '{ModeCount, 8'hF0, 1'b1, 1'b0, 8'd0},
    '{ModeMap, 8'h55, 1'b0, 1'b0, 8'd0},
    '{ModeMap, 8'hAA, 1'b0, 1'b0, 8'd0},
    '{ModeMap, 8'h0F, 1'b0, 1'b0, 8'd0},
    '{ModeMap, 8'hF0, 1'b1, 1'b0, 8'd0}
  };

  initial begin
    int unsigned sent;
    foreach (bins_m[i]) bins_m[i] = 0;
    foreach (lut_m[i]) lut_m[i] = '0;
    total_m = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      send_request(plan[i].mode, plan[i].pixel, plan[i].last, plan[i].known,
                   plan[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      sender_gap_pct = (phase == 0) ? 10 : (phase == 1) ? 61 : 0;
      sent = 0;
      while (sent < 280) begin
        case ($urandom_range(9))
          0: begin
            // Stray request with fully random fields.
            send_request(pass_mode_e'($urandom_range(1)), 8'($urandom),
                         1'($urandom), 1'b0, '0);
            sent++;
          end
          1: begin
            send_image(1 + $urandom_range(3), 255);
            sent += 8;
          end
          default: begin
            automatic int unsigned n = 4 + $urandom_range(28);
            send_image(n, (n > 16) ? 255 : $urandom_range(1, 40));
            sent += 2 * n;
          end
        endcase
      end
    end

    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### histogram_equalizer.f
sv/heq_pkg.sv
sv/histogram_equalizer.sv
bench/tb_top.sv
